### src/rtwe_pkg.sv
// ----------------------------------------------------------------------------
// rtwe_pkg: shared types and constants of the two-warrior Redcode executor
// Holds the arena word layout, request and opcode codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtwe_pkg;

  // Arena geometry: addresses and fields wrap at the arena size.
  localparam int unsigned AddrW     = 12;
  localparam int unsigned ArenaSize = 1 << AddrW;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] ReqWrite   = 2'd0;
  localparam logic [1:0] ReqRead    = 2'd1;
  localparam logic [1:0] ReqStep    = 2'd2;
  localparam logic [1:0] ReqRestart = 2'd3;

  // Opcodes.
  localparam logic [3:0] OpDat = 4'd0;
  localparam logic [3:0] OpMov = 4'd1;
  localparam logic [3:0] OpAdd = 4'd2;
  localparam logic [3:0] OpSub = 4'd3;
  localparam logic [3:0] OpJmp = 4'd4;
  localparam logic [3:0] OpJmz = 4'd5;
  localparam logic [3:0] OpJmg = 4'd6;
  localparam logic [3:0] OpDjz = 4'd7;
  localparam logic [3:0] OpCmp = 4'd8;

  // Addressing modes.
  localparam logic [1:0] ModeImm     = 2'd0;
  localparam logic [1:0] ModeDirect  = 2'd1;
  localparam logic [1:0] ModeIndir   = 2'd2;
  localparam logic [1:0] ModeIllegal = 2'd3;

  // Game outcome codes.
  localparam logic [1:0] ResRunning   = 2'd0;
  localparam logic [1:0] ResFirstWon  = 2'd1;
  localparam logic [1:0] ResSecondWon = 2'd2;

  // One arena word, 32 bits.
  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       a_mode;
    logic [1:0]       b_mode;
    logic [AddrW-1:0] a_val;
    logic [AddrW-1:0] b_val;
  } word_t;

  // Memory address source.
  typedef enum logic [2:0] {
    AD_REQ,
    AD_PC,
    AD_PA,
    AD_PA_IND,
    AD_PB,
    AD_PB_IND,
    AD_TGT,
    AD_CLR
  } addr_sel_e;

  // Memory write data source.
  typedef enum logic [2:0] {
    WD_REQ,
    WD_DATA,
    WD_ADD,
    WD_SUB,
    WD_DEC,
    WD_ZERO
  } wd_sel_e;

  // Next program counter source.
  typedef enum logic [1:0] {
    NP_INC,
    NP_TWO,
    NP_A
  } np_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      mem_en;
    logic      mem_we;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      ld_req;
    logic      ld_rd;
    logic      set_mover;
    logic      ld_ins;
    logic      ld_data;
    logic      data_imm;
    logic      ld_tgt;
    logic      commit;
    np_sel_e   np_sel;
    logic      lose;
    logic      restart;
    logic      inc_clr;
    logic      ld_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       running;
    logic [3:0] op;
    logic [1:0] a_mode;
    logic [1:0] b_mode;
    logic       rd_dat;
    logic       rd_b_zero;
    logic       rd_b_one;
    logic       cmp_eq;
    logic       imm_eq;
    logic       clr_last;
  } status_t;

  // Result beat payload without padding.
  typedef struct packed {
    logic             mover;
    logic [1:0]       outcome;
    logic [AddrW-1:0] pc_second;
    logic [AddrW-1:0] pc_first;
    logic [AddrW-1:0] read_b;
    logic [AddrW-1:0] read_a;
    logic [1:0]       read_b_mode;
    logic [1:0]       read_a_mode;
    logic [3:0]       read_op;
  } result_t;

endpackage

`default_nettype wire

### src/rtwe_datapath.sv
// ----------------------------------------------------------------------------
// rtwe_datapath: arena memory, counters and operand registers
// Executes the memory accesses and register loads that the controller
// commands, and reports decode and compare flags back to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtwe_datapath
  import rtwe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire logic [AddrW-1:0] req_addr_i,
  input  wire word_t            req_word_i,
  input  wire logic [AddrW-1:0] start_first_i,
  input  wire logic [AddrW-1:0] start_second_i,
  output result_t               result_o
);

  logic [31:0]      mem [ArenaSize];
  word_t            rdata_q;
  logic [AddrW-1:0] req_addr_q;
  word_t            req_word_q;
  word_t            ins_q;
  word_t            data_q;
  logic [AddrW-1:0] tgt_q;
  word_t            rd_q;
  logic             mover_q;
  logic [AddrW-1:0] cnt1_q;
  logic [AddrW-1:0] cnt2_q;
  logic             turn_q;
  logic [1:0]       res_q;
  logic [AddrW-1:0] clr_q;
  result_t          out_q;

  logic [AddrW-1:0] pc;
  logic [AddrW-1:0] pa;
  logic [AddrW-1:0] pb;
  logic [AddrW-1:0] mem_addr;
  word_t            wdata;
  logic [AddrW-1:0] npc;

  // Operand addresses, all relative to the executing instruction.
  assign pc = turn_q ? cnt2_q : cnt1_q;
  assign pa = pc + ins_q.a_val;
  assign pb = pc + ins_q.b_val;

  always_comb begin
    case (cmd_i.addr_sel)
      AD_REQ:    mem_addr = req_addr_q;
      AD_PC:     mem_addr = pc;
      AD_PA:     mem_addr = pa;
      AD_PA_IND: mem_addr = rdata_q.b_val + pa;
      AD_PB:     mem_addr = pb;
      AD_PB_IND: mem_addr = rdata_q.b_val + pb;
      AD_TGT:    mem_addr = tgt_q;
      AD_CLR:    mem_addr = clr_q;
      default:   mem_addr = pc;
    endcase
  end

  // Write data: a full word, or the fetched word with a new B field.
  always_comb begin
    wdata = rdata_q;
    case (cmd_i.wd_sel)
      WD_REQ:  wdata = req_word_q;
      WD_DATA: wdata = data_q;
      WD_ADD:  wdata.b_val = rdata_q.b_val + data_q.b_val;
      WD_SUB:  wdata.b_val = rdata_q.b_val - data_q.b_val;
      WD_DEC:  wdata.b_val = rdata_q.b_val - AddrW'(1);
      WD_ZERO: wdata = '0;
      default: wdata = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.np_sel)
      NP_INC:  npc = pc + AddrW'(1);
      NP_TWO:  npc = pc + AddrW'(2);
      NP_A:    npc = pa;
      default: npc = pc + AddrW'(1);
    endcase
  end

  // Single-port arena with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_en) begin
      if (cmd_i.mem_we) begin
        mem[mem_addr] <= wdata;
      end else begin
        rdata_q <= word_t'(mem[mem_addr]);
      end
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_addr_q <= req_addr_i;
      req_word_q <= req_word_i;
    end
    if (cmd_i.ld_req) begin
      rd_q    <= '0;
      mover_q <= 1'b0;
    end else begin
      if (cmd_i.ld_rd) begin
        rd_q <= rdata_q;
      end
      if (cmd_i.set_mover) begin
        mover_q <= turn_q;
      end
    end
    if (cmd_i.ld_ins) begin
      ins_q <= rdata_q;
    end
    if (cmd_i.ld_data) begin
      // An immediate A operand is a word whose B field is the A value.
      if (cmd_i.data_imm) begin
        data_q <= word_t'({20'd0, ins_q.a_val});
      end else begin
        data_q <= rdata_q;
      end
    end
    if (cmd_i.ld_tgt) begin
      tgt_q <= mem_addr;
    end
    if (cmd_i.ld_out) begin
      out_q <= '{
        read_op:     rd_q.op,
        read_a_mode: rd_q.a_mode,
        read_b_mode: rd_q.b_mode,
        read_a:      rd_q.a_val,
        read_b:      rd_q.b_val,
        pc_first:    cnt1_q,
        pc_second:   cnt2_q,
        outcome:     res_q,
        mover:       mover_q
      };
    end
  end

  // Game state and clearing sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q <= '0;
      cnt2_q <= '0;
      turn_q <= 1'b0;
      res_q  <= ResRunning;
      clr_q  <= '0;
    end else begin
      if (cmd_i.inc_clr) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.restart) begin
        cnt1_q <= start_first_i;
        cnt2_q <= start_second_i;
        turn_q <= 1'b0;
        res_q  <= ResRunning;
      end else if (cmd_i.lose) begin
        res_q <= turn_q ? ResFirstWon : ResSecondWon;
      end else if (cmd_i.commit) begin
        if (turn_q) begin
          cnt2_q <= npc;
        end else begin
          cnt1_q <= npc;
        end
        turn_q <= ~turn_q;
      end
    end
  end

  assign status_o.running   = (res_q == ResRunning);
  assign status_o.op        = ins_q.op;
  assign status_o.a_mode    = ins_q.a_mode;
  assign status_o.b_mode    = ins_q.b_mode;
  assign status_o.rd_dat    = (rdata_q.op == OpDat);
  assign status_o.rd_b_zero = (rdata_q.b_val == '0);
  assign status_o.rd_b_one  = (rdata_q.b_val == AddrW'(1));
  assign status_o.cmp_eq    = (data_q.b_val == rdata_q.b_val);
  assign status_o.imm_eq    = (data_q.b_val == ins_q.b_val);
  assign status_o.clr_last  = (clr_q == AddrW'(ArenaSize - 1));

  assign result_o = out_q;

endmodule

`default_nettype wire

### src/rtwe_controller.sv
// ----------------------------------------------------------------------------
// rtwe_controller: sequencer of the Redcode executor
// Clears the arena after reset, then walks each request through its
// memory accesses and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtwe_controller
  import rtwe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] req_type_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cmd_t            cmd_o,
  input  wire status_t    status_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR,
    S_RD,
    S_RD2,
    S_FETCH,
    S_LOAD,
    S_EXEC,
    S_AR2,
    S_AR3,
    S_BSTART,
    S_BIND,
    S_MOVW,
    S_TRD,
    S_TOP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;
  logic   fatal;
  logic   is_mov;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_mov   = (status_i.op == OpMov);

  // Instructions that end the game for the warrior that runs them.
  always_comb begin
    case (status_i.op)
      OpMov, OpAdd, OpSub:
        fatal = (status_i.a_mode == ModeIllegal) || (status_i.b_mode == ModeImm) ||
                (status_i.b_mode == ModeIllegal);
      OpCmp:
        fatal = (status_i.a_mode == ModeIllegal) || (status_i.b_mode == ModeIllegal);
      OpJmp, OpJmz, OpJmg, OpDjz:
        fatal = 1'b0;
      default:
        fatal = 1'b1;
    endcase
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.addr_sel = AD_PC;
    cmd_o.wd_sel   = WD_ZERO;
    cmd_o.np_sel   = NP_INC;
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = AD_CLR;
        cmd_o.inc_clr  = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.ld_req = 1'b1;
          case (req_type_i)
            ReqWrite:   state_d = S_WR;
            ReqRead:    state_d = S_RD;
            ReqStep:    state_d = status_i.running ? S_FETCH : S_DONE;
            ReqRestart: begin
              cmd_o.restart = 1'b1;
              state_d = S_DONE;
            end
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_WR: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = AD_REQ;
        cmd_o.wd_sel   = WD_REQ;
        state_d = S_DONE;
      end
      S_RD: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.addr_sel = AD_REQ;
        state_d = S_RD2;
      end
      S_RD2: begin
        cmd_o.ld_rd = 1'b1;
        state_d = S_DONE;
      end
      S_FETCH: begin
        cmd_o.mem_en    = 1'b1;
        cmd_o.addr_sel  = AD_PC;
        cmd_o.set_mover = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.ld_ins = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (fatal) begin
          cmd_o.lose = 1'b1;
          state_d = S_DONE;
        end else begin
          case (status_i.op)
            OpJmp: begin
              cmd_o.commit = 1'b1;
              cmd_o.np_sel = NP_A;
              state_d = S_DONE;
            end
            OpJmz, OpJmg, OpDjz: begin
              cmd_o.ld_tgt   = 1'b1;
              cmd_o.addr_sel = AD_PB;
              state_d = S_TRD;
            end
            default: begin
              // Fetch the A operand.
              if (status_i.a_mode == ModeImm) begin
                cmd_o.ld_data  = 1'b1;
                cmd_o.data_imm = 1'b1;
                state_d = S_BSTART;
              end else begin
                cmd_o.mem_en   = 1'b1;
                cmd_o.addr_sel = AD_PA;
                state_d = S_AR2;
              end
            end
          endcase
        end
      end
      S_AR2: begin
        if (status_i.a_mode == ModeDirect) begin
          cmd_o.ld_data = 1'b1;
          state_d = S_BSTART;
        end else begin
          cmd_o.mem_en   = 1'b1;
          cmd_o.addr_sel = AD_PA_IND;
          state_d = S_AR3;
        end
      end
      S_AR3: begin
        cmd_o.ld_data = 1'b1;
        state_d = S_BSTART;
      end
      S_BSTART: begin
        // Locate the B operand.
        if (status_i.b_mode == ModeImm) begin
          cmd_o.commit = 1'b1;
          cmd_o.np_sel = status_i.imm_eq ? NP_INC : NP_TWO;
          state_d = S_DONE;
        end else if (status_i.b_mode == ModeDirect) begin
          cmd_o.ld_tgt   = 1'b1;
          cmd_o.addr_sel = AD_PB;
          state_d = is_mov ? S_MOVW : S_TRD;
        end else begin
          cmd_o.mem_en   = 1'b1;
          cmd_o.addr_sel = AD_PB;
          state_d = S_BIND;
        end
      end
      S_BIND: begin
        cmd_o.ld_tgt   = 1'b1;
        cmd_o.addr_sel = AD_PB_IND;
        state_d = is_mov ? S_MOVW : S_TRD;
      end
      S_MOVW: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = AD_TGT;
        cmd_o.wd_sel   = WD_DATA;
        cmd_o.commit   = 1'b1;
        state_d = S_DONE;
      end
      S_TRD: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.addr_sel = AD_TGT;
        state_d = S_TOP;
      end
      S_TOP: begin
        // Work on the target word and pick the next counter value.
        cmd_o.addr_sel = AD_TGT;
        cmd_o.commit   = 1'b1;
        state_d = S_DONE;
        case (status_i.op)
          OpAdd: begin
            cmd_o.mem_en = 1'b1;
            cmd_o.mem_we = 1'b1;
            cmd_o.wd_sel = WD_ADD;
          end
          OpSub: begin
            cmd_o.mem_en = 1'b1;
            cmd_o.mem_we = 1'b1;
            cmd_o.wd_sel = WD_SUB;
          end
          OpJmz: begin
            cmd_o.np_sel = (status_i.rd_dat && status_i.rd_b_zero) ? NP_A : NP_INC;
          end
          OpJmg: begin
            cmd_o.np_sel = (status_i.rd_dat && !status_i.rd_b_zero) ? NP_A : NP_INC;
          end
          OpDjz: begin
            cmd_o.mem_en = 1'b1;
            cmd_o.mem_we = 1'b1;
            cmd_o.wd_sel = WD_DEC;
            cmd_o.np_sel = status_i.rd_b_one ? NP_A : NP_INC;
          end
          default: begin
            cmd_o.np_sel = status_i.cmp_eq ? NP_INC : NP_TWO;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/redcode_two_warrior_executor.sv
// ----------------------------------------------------------------------------
// redcode_two_warrior_executor: two-warrior Redcode arena executor
// Holds a 4096-word arena and two program counters, and runs one request
// per input beat: write a word, read a word, step a warrior, or restart.
//
// Usage:
//   Input beats arrive on s_axis; tuser carries the request kind and tdata
//   the address and word fields. Every request yields one result beat on
//   m_axis with the read word, both counters, the outcome and the mover.
//   The user sets the start addresses through the APB port while idle; the block does not enforce this.
// Sequencing:
//   a step runs fetch, decode, up to four operand reads and one write
//   through the single arena port. A new beat is taken at the edge after
//   the result has been loaded into the output register.
// Reset:
//   Counters, turn and outcome clear at once; then a sweep writes zero to
//   all 4096 arena words, one per cycle, and s_axis_tready stays low until
//   the sweep ends. Configuration writes are taken during the sweep.
// Stall:
//   The result beat holds in the output register while m_axis_tready is
//   low; the block takes one more request and waits with its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module redcode_two_warrior_executor
  import rtwe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: word_addr[11:0], word_op[15:12], word_a_mode[17:16],
  //        word_b_mode[19:18], word_a[31:20], word_b[43:32], zero pad.
  input  wire logic [47:0] s_axis_tdata,
  // tuser: req_type[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: read_op[3:0], read_a_mode[5:4], read_b_mode[7:6], read_a[19:8],
  //        read_b[31:20], pc_first[43:32], pc_second[55:44],
  //        outcome[57:56], mover[58], zero pad.
  output logic [63:0]      m_axis_tdata,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cmd_t             cmd;
  status_t          status;
  result_t          result;
  word_t            req_word;
  logic [AddrW-1:0] start_first_q;
  logic [AddrW-1:0] start_second_q;
  logic             cfg_wr;

  // Start address registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= '0;
      start_second_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        start_second_q <= pwdata[AddrW-1:0];
      end else begin
        start_first_q <= pwdata[AddrW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {20'd0, start_second_q} : {20'd0, start_first_q};

  // Unpack the request beat.
  assign req_word.op     = s_axis_tdata[15:12];
  assign req_word.a_mode = s_axis_tdata[17:16];
  assign req_word.b_mode = s_axis_tdata[19:18];
  assign req_word.a_val  = s_axis_tdata[31:20];
  assign req_word.b_val  = s_axis_tdata[43:32];

  rtwe_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rtwe_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_addr_i     (s_axis_tdata[11:0]),
    .req_word_i     (req_word),
    .start_first_i  (start_first_q),
    .start_second_i (start_second_q),
    .result_o       (result)
  );

  assign m_axis_tdata = {5'd0, result};

endmodule

`default_nettype wire
